// ===== src/seismic_sample_to_float_top_assert.svh =====
// Assertion macros for the sample converter
`ifndef SEISMIC_SAMPLE_TO_FLOAT_TOP_ASSERT_SVH
`define SEISMIC_SAMPLE_TO_FLOAT_TOP_ASSERT_SVH

// Check that a condition implies a consequence on the same edge
`define SSF_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a consequence on the following edge
`define SSF_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/ssf_pkg.sv =====
package ssf_pkg;
    localparam logic [3:0] FMT_IBM   = 4'd1;
    localparam logic [3:0] FMT_INT32 = 4'd2;
    localparam logic [3:0] FMT_INT16 = 4'd3;
    localparam logic [3:0] FMT_IEEE  = 4'd5;
    localparam logic [3:0] FMT_INT8  = 4'd8;
    localparam logic [3:0] FMT_RESET = FMT_IBM;

    localparam logic CFG_FORMAT = 1'b0;
    localparam logic CFG_RAW    = 1'b1;

    // Front-end result: sign, magnitude and binary scale for the packer
    typedef struct packed {
        logic              sign;
        logic [31:0]       mag;
        logic signed [9:0] scale;
        logic              pass;
        logic [31:0]       pass_word;
        logic              err;
    } t_pre;
endpackage

// ===== src/ssf_decode.sv =====
module ssf_decode (
    input  logic [3:0]   i_format,
    input  logic         i_raw,
    input  logic [31:0]  i_word,
    output ssf_pkg::t_pre o_pre
);
    logic [31:0] v_neg32;
    logic [15:0] v_neg16;
    logic [7:0]  v_neg8;

    assign v_neg32 = 32'd0 - i_word;
    assign v_neg16 = 16'd0 - i_word[15:0];
    assign v_neg8  = 8'd0 - i_word[7:0];

    // Split the sample into sign, magnitude and scale per format
    always_comb begin
        o_pre = '0;
        case (i_format)
            ssf_pkg::FMT_IBM: begin
                o_pre.sign  = i_word[31];
                o_pre.mag   = {8'd0, i_word[23:0]};
                o_pre.scale = $signed({3'd0, i_word[30:24]}) * 10'sd4 - 10'sd280;
            end
            ssf_pkg::FMT_INT32: begin
                o_pre.sign      = i_word[31];
                o_pre.mag       = i_word[31] ? v_neg32 : i_word;
                o_pre.pass      = i_raw;
                o_pre.pass_word = i_word;
            end
            ssf_pkg::FMT_INT16: begin
                o_pre.sign      = i_word[15];
                o_pre.mag       = {16'd0, i_word[15] ? v_neg16 : i_word[15:0]};
                o_pre.pass      = i_raw;
                o_pre.pass_word = {16'd0, i_word[15:0]};
            end
            ssf_pkg::FMT_IEEE: begin
                o_pre.pass      = 1'b1;
                o_pre.pass_word = i_word;
            end
            ssf_pkg::FMT_INT8: begin
                o_pre.sign      = i_word[7];
                o_pre.mag       = {24'd0, i_word[7] ? v_neg8 : i_word[7:0]};
                o_pre.pass      = i_raw;
                o_pre.pass_word = {24'd0, i_word[7:0]};
            end
            default: begin
                o_pre.err  = 1'b1;
                o_pre.pass = 1'b1;
            end
        endcase
    end
endmodule

// ===== src/ssf_pack.sv =====
module ssf_pack (
    input  ssf_pkg::t_pre i_pre,
    output logic [31:0]   o_word
);
    logic [4:0]         v_p;
    logic [31:0]        v_norm;
    logic signed [10:0] v_e;
    logic signed [10:0] v_sh;
    logic [5:0]         v_drop;
    logic [63:0]        v_ext;
    logic [31:0]        v_sig;
    logic               v_g;
    logic               v_st;
    logic [24:0]        v_rnd;
    logic [7:0]         v_eb;
    logic [31:0]        v_res;

    // Find the leading one
    always_comb begin
        v_p = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (i_pre.mag[i]) begin
                v_p = 5'(i);
            end
        end
    end

    // Align to a 24-bit significand, grading the dropped bits
    always_comb begin
        v_norm = i_pre.mag << (5'd31 - v_p);
        v_e    = 11'(i_pre.scale) + 11'($signed({6'd0, v_p}));
        v_sh   = (v_e < -11'sd126) ? (-11'sd126 - v_e) : 11'sd0;
        v_drop = (v_sh > 11'sd40) ? 6'd40 : 6'(v_sh);
        v_ext  = {v_norm, 32'd0} >> v_drop;
        v_sig  = v_ext[63:32];
        v_g    = v_sig[7];
        v_st   = (v_sig[6:0] != 7'd0) || (v_ext[31:0] != 32'd0);
        v_rnd  = {1'b0, v_sig[31:8]} + 25'(v_g && (v_st || v_sig[8]));
        v_eb   = (v_sh != 11'sd0) ? 8'd0 : 8'(v_e + 11'sd126);
        v_res  = ({1'b0, v_eb, 23'd0}) + {7'd0, v_rnd};
        if (i_pre.pass) begin
            o_word = i_pre.err ? 32'd0 : i_pre.pass_word;
        end else if (i_pre.mag == 32'd0) begin
            o_word = {i_pre.sign, 31'd0};
        end else if (v_e > 11'sd127) begin
            o_word = {i_pre.sign, 8'hff, 23'd0};
        end else begin
            o_word = {i_pre.sign, v_res[30:0]};
        end
    end
endmodule

// ===== src/seismic_sample_to_float_top.sv =====
// Converts one trace sample per cycle (unless the output side stalls) to an IEEE single
// (IBM hex float, int32/16/8) or passes it through (IEEE format, raw integer mode). The
// item passes an input register, one pass of decode and rounding logic, and a result
// register that is refilled in the cycle it is taken, so a new item can be accepted
// every cycle while the output is not stalled. Unsupported format codes give zero with
// o_format_error set. Write configuration only while no item is in flight.
`include "seismic_sample_to_float_top_assert.svh"
module seismic_sample_to_float_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_sample_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_word,
    output logic        o_format_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [3:0]  r_format;
    logic        r_raw;
    logic        r_in_valid;
    logic [31:0] r_in_word;
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic        r_out_err;
    logic        v_adv;
    logic        v_in_take;
    ssf_pkg::t_pre v_pre;
    logic [31:0] v_word;

    assign o_cfg_ready    = 1'b1;
    assign v_adv          = !r_out_valid || !i_stall;
    assign o_stall        = r_in_valid && !v_adv;
    assign v_in_take      = i_valid && !o_stall;
    assign o_valid        = r_out_valid;
    assign o_result_word  = r_out_word;
    assign o_format_error = r_out_err;

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= ssf_pkg::FMT_RESET;
            r_raw    <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index[0] == ssf_pkg::CFG_FORMAT) r_format <= i_cfg_data[3:0];
            else r_raw <= i_cfg_data[0];
        end
    end

    ssf_decode u_dec (.i_format(r_format), .i_raw(r_raw), .i_word(r_in_word), .o_pre(v_pre));
    ssf_pack u_pack (.i_pre(v_pre), .o_word(v_word));

    // Advance the two-register pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (v_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (v_adv || !r_in_valid) begin
                r_in_valid <= v_in_take;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_in_take) r_in_word <= i_sample_word;
        if (v_adv && r_in_valid) begin
            r_out_word <= v_word;
            r_out_err  <= v_pre.err;
        end
    end

    `SSF_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, r_out_valid && r_out_err, r_out_word == 32'd0)
    `SSF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_out_valid && i_stall, r_out_valid && $stable(r_out_word))
    `SSF_ASSERT_IMPL(a_stall, i_clk, i_rst_n, o_stall, r_in_valid && r_out_valid)
endmodule

// ===== verif/tb_seismic_sample_to_float_top.sv =====
`timescale 1ns / 100ps
module tb_seismic_sample_to_float_top;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_sample_word = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_result_word;
    logic        o_format_error;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    typedef struct packed {
        logic [31:0] word;
        logic        err;
    } t_conv;

    logic [3:0] fmt_sel;
    logic       raw_sel;
    t_conv      conv_q[$];
    int         mismatches = 0;
    int         items_sent = 0;
    int         results_seen = 0;
    bit         rx_idle_on = 1'b1;

    seismic_sample_to_float_top DUT (.*);

    always #4 i_clk = ~i_clk;

    // Round sign * mag * 2^k to single, nearest even
    function automatic logic [31:0] round_single(logic s, logic [31:0] mag, int k);
        int p;
        int e;
        int eb;
        int q;
        int drop;
        logic [63:0] sig;
        logic [63:0] rem;
        logic [63:0] half;
        if (mag == 0) return {s, 31'd0};
        p = 31;
        while (!mag[p]) p--;
        e = p + k;
        if (e > 127) return {s, 31'h7f800000};
        if (e < -126) begin
            eb = 1;
            q = -149;
        end else begin
            eb = e + 127;
            q = e - 23;
        end
        drop = q - k;
        if (drop <= 0) begin
            sig = 64'(mag) << (-drop);
        end else if (drop >= 33) begin
            sig = 0;
        end else begin
            rem = 64'(mag) & ((64'd1 << drop) - 1);
            half = 64'd1 << (drop - 1);
            sig = 64'(mag) >> drop;
            if (rem > half || (rem == half && sig[0])) sig++;
        end
        return {s, 31'd0} | ((32'(eb - 1) << 23) + sig[31:0]);
    endfunction

    function automatic logic [31:0] int_single(logic [31:0] w, int bits);
        logic [31:0] full;
        logic [31:0] v;
        logic [31:0] mag;
        logic        s;
        full = (bits >= 32) ? 32'hffffffff : ((32'd1 << bits) - 1);
        v = w & full;
        s = v[bits-1];
        mag = s ? ((32'd0 - v) & full) : v;
        return round_single(s, mag, 0);
    endfunction

    function automatic t_conv convert_sample(logic [31:0] w);
        t_conv c;
        c = '0;
        case (fmt_sel)
            ssf_pkg::FMT_IBM:
                c.word = round_single(w[31], {8'd0, w[23:0]},
                                      4 * (int'(w[30:24]) - 64) - 24);
            ssf_pkg::FMT_INT32: c.word = raw_sel ? w : int_single(w, 32);
            ssf_pkg::FMT_INT16: c.word = raw_sel ? {16'd0, w[15:0]} : int_single(w, 16);
            ssf_pkg::FMT_IEEE:  c.word = w;
            ssf_pkg::FMT_INT8:  c.word = raw_sel ? {24'd0, w[7:0]} : int_single(w, 8);
            default:            c.err = 1'b1;
        endcase
        return c;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h (fmt %0d raw %0d)", what, got, want,
                 fmt_sel, raw_sel);
        mismatches++;
    endtask

    // Drive one sample, hold until taken
    task automatic send_sample(logic [31:0] w);
        int n_idle;
        n_idle = $urandom_range(0, 15) * ($urandom_range(0, 3) == 0);
        if (n_idle != 0) begin
            i_valid <= 1'b0;
            repeat (n_idle) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_word <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        conv_q.push_back(convert_sample(w));
        items_sent++;
        @(negedge i_clk);
    endtask

    // Random stall on the result side
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end else begin
                i_stall <= rx_idle_on && ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_conv want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (conv_q.size() == 0) begin
                report_mismatch("unexpected result", o_result_word, 32'd0);
            end else begin
                want = conv_q.pop_front();
                if (o_result_word !== want.word)
                    report_mismatch("result_word", o_result_word, want.word);
                if (o_format_error !== want.err)
                    report_mismatch("format_error", {31'd0, o_format_error}, {31'd0, want.err});
            end
        end
    end

    task automatic drain;
        i_valid <= 1'b0;
        while (conv_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == ssf_pkg::CFG_FORMAT) fmt_sel = data[3:0];
        else raw_sel = data[0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 5))
            0: return 32'h80000000 >> $urandom_range(0, 31);
            1: return ~(32'h1 << $urandom_range(0, 31));
            2: return {1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)), 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Reset values and IBM corner cases
    task automatic test_ibm_directed;
        logic [31:0] cases[12] = '{32'h00000000, 32'h80000000, 32'h7fffffff, 32'hffffffff,
                                   32'h41100000, 32'hc276a000, 32'h00000001, 32'h3f000001,
                                   32'h60ffffff, 32'h7f000000, 32'h21800000, 32'h22ffffff};
        foreach (cases[i]) send_sample(cases[i]);
    endtask

    // Integer formats and IEEE pass-through in both modes at their extremes
    task automatic test_int_directed;
        logic [31:0] cases[6] = '{32'h80000000, 32'h7fffffff, 32'hffffff80, 32'h00018000,
                                  32'h0000007f, 32'h01000001};
        logic [3:0]  fmts[4] = '{ssf_pkg::FMT_INT32, ssf_pkg::FMT_INT16, ssf_pkg::FMT_INT8,
                                 ssf_pkg::FMT_IEEE};
        for (int r = 0; r < 2; r++)
            foreach (fmts[f]) begin
                write_reg(ssf_pkg::CFG_RAW, 32'(r));
                write_reg(ssf_pkg::CFG_FORMAT, {28'hfffffff, fmts[f]});
                send_sample(cases[f]);
                send_sample(cases[f + 2]);
            end
    endtask

    // Invalid codes, fixed point among them
    task automatic test_invalid_formats;
        logic [3:0] bad[3] = '{4'd0, 4'd4, 4'd15};
        foreach (bad[i]) begin
            write_reg(ssf_pkg::CFG_FORMAT, {28'd0, bad[i]});
            send_sample($urandom);
        end
    endtask

    // Random streams through several settings
    task automatic test_random_streams;
        logic [3:0] fmts[6] = '{ssf_pkg::FMT_IBM, ssf_pkg::FMT_INT32, ssf_pkg::FMT_INT16,
                                ssf_pkg::FMT_IEEE, ssf_pkg::FMT_INT8, 4'd6};
        for (int ph = 0; ph < 12; ph++) begin
            rx_idle_on = (ph % 4 != 3);
            write_reg(ssf_pkg::CFG_RAW, 32'($urandom_range(0, 1)));
            write_reg(ssf_pkg::CFG_FORMAT,
                      {28'd0, (ph < 6) ? fmts[ph] : fmts[$urandom_range(0, 5)]});
            repeat (40) send_sample(random_word());
        end
        rx_idle_on = 1'b1;
    endtask

    initial begin
        fmt_sel = ssf_pkg::FMT_RESET;
        raw_sel = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_ibm_directed();
        test_int_directed();
        test_invalid_formats();
        test_random_streams();
        drain();
        $display("covered %0d samples, %0d results, all formats in both modes",
                 items_sent, results_seen);
        if (mismatches == 0 && conv_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("FAIL");
        $finish;
    end
endmodule
